[hw/rtl/bencode_stream_tokenizer_macros.svh]
// Assertion helpers shared by the checker.
`ifndef BENCODE_STREAM_TOKENIZER_MACROS_SVH
`define BENCODE_STREAM_TOKENIZER_MACROS_SVH

// Check an implication every clock outside reset.
`define BST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bencode tokenizer check failed");

// Check a property that also holds during reset.
`define BST_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bencode tokenizer check failed");

`endif

[hw/rtl/bst_pkg.sv]
`default_nettype none
package bst_pkg;
    // Token kinds
    localparam logic [2:0] K_INT    = 3'd0;
    localparam logic [2:0] K_HDR    = 3'd1;
    localparam logic [2:0] K_BYTE   = 3'd2;
    localparam logic [2:0] K_LSTART = 3'd3;
    localparam logic [2:0] K_LEND   = 3'd4;
    localparam logic [2:0] K_ERR    = 3'd5;
    // Error codes
    localparam logic [2:0] E_NONE   = 3'd0;
    localparam logic [2:0] E_TYPE   = 3'd1;
    localparam logic [2:0] E_LEN    = 3'd2;
    localparam logic [2:0] E_TRUNC  = 3'd3;
    localparam logic [2:0] E_INT    = 3'd4;
    localparam logic [2:0] E_DEEP   = 3'd5;
    // Characters
    localparam logic [7:0] C_I      = 8'h69;
    localparam logic [7:0] C_L      = 8'h6C;
    localparam logic [7:0] C_E      = 8'h65;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;

    // Byte class computed by the front stage
    typedef struct packed {
        logic [7:0] byte_val;
        logic       eob;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_i;
        logic       is_l;
        logic       is_e;
        logic       is_colon;
        logic       is_minus;
    } t_cls;

    // One result token
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] int_value;
        logic [31:0] len;
        logic [7:0]  payload;
        logic [4:0]  depth;
        logic [2:0]  code;
        logic        done;
    } t_tok;
endpackage
`default_nettype wire

[hw/rtl/bst_front.sv]
`default_nettype none
// Accept bytes and classify them into a one-entry register.
module bst_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [7:0]       i_byte,
    input  wire              i_eob,
    output logic             o_valid,
    input  wire              i_ready,
    output bst_pkg::t_cls    o_cls
);
    logic          r_valid;
    bst_pkg::t_cls r_cls;
    bst_pkg::t_cls n_cls;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    // Classify the incoming byte
    always_comb begin
        n_cls          = '0;
        n_cls.byte_val = i_byte;
        n_cls.eob      = i_eob;
        n_cls.is_digit = (i_byte >= bst_pkg::C_ZERO) && (i_byte <= bst_pkg::C_NINE);
        n_cls.digit    = 4'(i_byte - bst_pkg::C_ZERO);
        n_cls.is_i     = (i_byte == bst_pkg::C_I);
        n_cls.is_l     = (i_byte == bst_pkg::C_L);
        n_cls.is_e     = (i_byte == bst_pkg::C_E);
        n_cls.is_colon = (i_byte == bst_pkg::C_COLON);
        n_cls.is_minus = (i_byte == bst_pkg::C_MINUS);
    end

    // Hold or advance the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/bst_back.sv]
`default_nettype none
// Run the parse state machine on classified bytes; register one token.
module bst_back #(
    parameter int MAX_DEPTH = 16,
    parameter int LEN_BITS  = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  bst_pkg::t_cls    i_cls,
    output logic             o_valid,
    input  wire              i_ready,
    output bst_pkg::t_tok    o_tok
);
    localparam int DW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ISTART = 8'b0000_0010,
        S_IMINUS = 8'b0000_0100,
        S_IDIG   = 8'b0000_1000,
        S_LDIG   = 8'b0001_0000,
        S_PAY    = 8'b0010_0000,
        S_ERR    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    localparam logic [63:0] LENMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);

    t_state        r_state, n_state;
    logic [63:0]   r_mag, n_mag;
    logic          r_neg, n_neg;
    logic          r_lz, n_lz;
    logic [LEN_BITS-1:0] r_rem, n_rem;
    logic [DW-1:0] r_depth, n_depth;
    logic          r_ovalid;
    bst_pkg::t_tok r_tok, n_tok;
    logic          n_have;
    logic          acc;

    logic [63:0]   mag10, sum;
    logic [67:0]   mag10w;
    logic          int_ovf, len_ovf;
    logic [63:0]   ilimit;
    logic [3:0]    d;

    assign o_ready = !r_ovalid || i_ready;
    assign acc     = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_tok   = r_tok;

    // Shared times-ten accumulate and range checks
    always_comb begin
        d       = i_cls.digit;
        mag10w  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0};
        mag10   = mag10w[63:0];
        sum     = mag10 + 64'(d);
        ilimit  = r_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        int_ovf = (mag10w[67:64] != 4'd0) || ({4'd0, mag10} + 68'(d) > {4'd0, ilimit});
        len_ovf = (mag10w[67:64] != 4'd0) || ({4'd0, mag10} + 68'(d) > {4'd0, LENMAX});
    end

    // Next state and token
    always_comb begin
        logic fin;
        logic own_err;
        fin     = 1'b0;
        own_err = 1'b0;
        n_state = r_state;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_lz    = r_lz;
        n_rem   = r_rem;
        n_depth = r_depth;
        n_have  = 1'b0;
        n_tok   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_mag = '0; n_neg = 1'b0; n_lz = 1'b0;
                if (i_cls.is_digit) begin
                    n_mag   = 64'(d);
                    n_state = S_LDIG;
                end else if (i_cls.is_i) begin
                    n_state = S_ISTART;
                end else if (i_cls.is_l) begin
                    if (32'(r_depth) >= 32'(MAX_DEPTH)) begin
                        n_have = 1'b1; n_tok.kind = bst_pkg::K_ERR;
                        n_tok.code = bst_pkg::E_DEEP; n_state = S_ERR;
                    end else begin
                        n_depth = r_depth + 1'b1;
                        n_have = 1'b1; n_tok.kind = bst_pkg::K_LSTART;
                    end
                end else if (i_cls.is_e && r_depth != '0) begin
                    n_depth = r_depth - 1'b1;
                    n_have = 1'b1; n_tok.kind = bst_pkg::K_LEND;
                    fin = 1'b1;
                end else begin
                    n_have = 1'b1; n_tok.kind = bst_pkg::K_ERR;
                    n_tok.code = bst_pkg::E_TYPE; n_state = S_ERR;
                end
            end
            S_ISTART, S_IMINUS, S_IDIG: begin
                if (r_state == S_ISTART && i_cls.is_minus) begin
                    n_neg = 1'b1; n_state = S_IMINUS;
                end else if (r_state == S_IDIG && i_cls.is_e) begin
                    n_have = 1'b1; n_tok.kind = bst_pkg::K_INT;
                    n_tok.int_value = r_neg ? (64'd0 - r_mag) : r_mag;
                    fin = 1'b1;
                end else if (i_cls.is_digit && !(r_state == S_IMINUS && d == 4'd0)
                             && !(r_state == S_IDIG && r_lz) && !int_ovf) begin
                    n_mag = sum; n_lz = (sum == 64'd0); n_state = S_IDIG;
                end else begin
                    n_have = 1'b1; n_tok.kind = bst_pkg::K_ERR;
                    n_tok.code = bst_pkg::E_INT; n_state = S_ERR;
                end
            end
            S_LDIG: begin
                if (i_cls.is_digit && !len_ovf) begin
                    n_mag = sum;
                end else if (i_cls.is_colon) begin
                    n_have = 1'b1; n_tok.kind = bst_pkg::K_HDR;
                    n_tok.len = r_mag[31:0];
                    n_rem = r_mag[LEN_BITS-1:0];
                    if (r_mag == 64'd0) fin = 1'b1;
                    else n_state = S_PAY;
                end else begin
                    n_have = 1'b1; n_tok.kind = bst_pkg::K_ERR;
                    n_tok.code = bst_pkg::E_LEN; n_state = S_ERR;
                end
            end
            S_PAY: begin
                n_have = 1'b1; n_tok.kind = bst_pkg::K_BYTE;
                n_tok.payload = i_cls.byte_val;
                n_rem = r_rem - 1'b1;
                if (r_rem == LEN_BITS'(1)) fin = 1'b1;
            end
            S_ERR, S_DONE: begin
            end
            default: begin
            end
        endcase
        if (fin) begin
            if (n_depth == '0) begin
                n_tok.done = 1'b1; n_state = S_DONE;
            end else begin
                n_state = S_IDLE;
            end
        end
        n_tok.depth = 5'(n_depth);
        // Flag truncation and clear the parser on the final byte
        if (i_cls.eob) begin
            own_err = n_have && (n_tok.kind == bst_pkg::K_ERR);
            if (!own_err && n_state != S_DONE && n_state != S_ERR) begin
                n_have = 1'b1;
                n_tok.kind = bst_pkg::K_ERR; n_tok.int_value = '0; n_tok.len = '0;
                n_tok.payload = '0; n_tok.code = bst_pkg::E_TRUNC; n_tok.done = 1'b0;
            end
            n_state = S_IDLE; n_mag = '0; n_neg = 1'b0; n_lz = 1'b0;
            n_rem = '0; n_depth = '0;
        end
    end

    // Advance state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mag    <= '0;
            r_neg    <= 1'b0;
            r_lz     <= 1'b0;
            r_rem    <= '0;
            r_depth  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (acc) begin
                r_state <= n_state;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_lz    <= n_lz;
                r_rem   <= n_rem;
                r_depth <= n_depth;
            end
            if (o_ready) r_ovalid <= acc && n_have;
        end
        if (acc && n_have) r_tok <= n_tok;
    end
endmodule
`default_nettype wire

[hw/rtl/bencode_stream_tokenizer.sv]
`default_nettype none
// Bencode stream tokenizer.
// Input channel: one byte per item (i_in_byte) with i_end_of_buffer set on the
// final byte of a buffer; i_valid / o_ready handshake.
// Output channel: zero or one token per byte, o_valid / i_ready handshake,
// fields o_token_kind, o_int_value, o_string_length, o_payload_byte,
// o_nesting_depth, o_error_code, o_object_done.
// Path: an accepted byte is loaded into the classify register; the parse state
// machine then turns it into a token that is loaded into the token register.
// Throughput: one byte per cycle while the receiver takes tokens; the parse step
// does one times-ten accumulate and its range compare each cycle.
// Errors are reported once and then nothing is emitted until the final byte;
// the final byte always returns the parser to its reset state.
// Reset (synchronous, active low) empties both stages and clears the parser.
// When the receiver stalls, the token register holds and back-pressure
// reaches the input after the classify register fills.
module bencode_stream_tokenizer #(
    parameter int MAX_DEPTH = 16,
    parameter int LEN_BITS  = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_end_of_buffer,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_token_kind,
    output logic signed [63:0] o_int_value,
    output logic [31:0] o_string_length,
    output logic [7:0]  o_payload_byte,
    output logic [4:0]  o_nesting_depth,
    output logic [2:0]  o_error_code,
    output logic        o_object_done
);
    logic          w_cvalid, w_cready;
    bst_pkg::t_cls w_cls;
    bst_pkg::t_tok w_tok;

    bst_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_byte(i_in_byte), .i_eob(i_end_of_buffer),
        .o_valid(w_cvalid), .i_ready(w_cready), .o_cls(w_cls)
    );

    bst_back #(.MAX_DEPTH(MAX_DEPTH), .LEN_BITS(LEN_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_cvalid), .o_ready(w_cready), .i_cls(w_cls),
        .o_valid(o_valid), .i_ready(i_ready), .o_tok(w_tok)
    );

    assign o_token_kind    = w_tok.kind;
    assign o_int_value     = w_tok.int_value;
    assign o_string_length = w_tok.len;
    assign o_payload_byte  = w_tok.payload;
    assign o_nesting_depth = w_tok.depth;
    assign o_error_code    = w_tok.code;
    assign o_object_done   = w_tok.done;
endmodule
`default_nettype wire

[hw/rtl/bst_checker.sv]
`default_nettype none
`include "bencode_stream_tokenizer_macros.svh"
// Port-level checks on the tokenizer.
module bst_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_valid,
    input wire        i_ready,
    input wire [2:0]  o_token_kind,
    input wire [2:0]  o_error_code,
    input wire        o_object_done
);
    `BST_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_token_kind))
    `BST_ASSERT(a_code, i_clk, i_rst_n, o_valid && o_token_kind != bst_pkg::K_ERR |-> o_error_code == bst_pkg::E_NONE)
    `BST_ASSERT(a_errc, i_clk, i_rst_n, o_valid && o_token_kind == bst_pkg::K_ERR |-> o_error_code != bst_pkg::E_NONE)
    `BST_ASSERT(a_done, i_clk, i_rst_n, o_valid && o_object_done |-> o_token_kind != bst_pkg::K_ERR && o_token_kind != bst_pkg::K_LSTART)
    `BST_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid)
endmodule

bind bencode_stream_tokenizer bst_checker u_bst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_token_kind(o_token_kind), .o_error_code(o_error_code),
    .o_object_done(o_object_done)
);
`default_nettype wire

[tb/tb_bencode_stream_tokenizer.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_bencode_stream_tokenizer;

    localparam int DEPTH_LIMIT = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [2:0] {
        PM_IDLE, PM_INT_START, PM_INT_MINUS, PM_INT_DIGITS,
        PM_LEN_DIGITS, PM_PAYLOAD, PM_ERROR, PM_DONE
    } t_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_in_byte;
    logic        i_end_of_buffer;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_token_kind;
    logic signed [63:0] o_int_value;
    logic [31:0] o_string_length;
    logic [7:0]  o_payload_byte;
    logic [4:0]  o_nesting_depth;
    logic [2:0]  o_error_code;
    logic        o_object_done;

    bencode_stream_tokenizer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_in_byte(i_in_byte), .i_end_of_buffer(i_end_of_buffer),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_token_kind(o_token_kind), .o_int_value(o_int_value),
        .o_string_length(o_string_length), .o_payload_byte(o_payload_byte),
        .o_nesting_depth(o_nesting_depth), .o_error_code(o_error_code),
        .o_object_done(o_object_done)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Parser mirror state
    t_mode       pm_mode;
    logic [63:0] pm_mag;
    logic        pm_neg;
    logic        pm_lz;
    logic [63:0] pm_left;
    logic [4:0]  pm_depth;

    bst_pkg::t_tok token_queue[$];
    int          mismatch_count;
    int          cycle_count;
    bit          calm;

    // Idle roughly 30 percent of cycles unless in a calm stretch
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 30);
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= bst_pkg::C_ZERO && b <= bst_pkg::C_NINE;
    endfunction

    task automatic parser_clear();
        pm_mode = PM_IDLE;
        pm_mag = '0;
        pm_neg = 1'b0;
        pm_lz = 1'b0;
        pm_left = '0;
        pm_depth = '0;
    endtask

    // Advance the mirror by one byte, queue the token if one results
    task automatic predict_token(logic [7:0] b, logic eob);
        bst_pkg::t_tok t;
        bit   have;
        logic [63:0] d;
        logic [63:0] lim;
        t = '0;
        have = 0;
        d = 64'(b - bst_pkg::C_ZERO);
        case (pm_mode)
            PM_IDLE: begin
                pm_mag = '0;
                pm_neg = 1'b0;
                pm_lz = 1'b0;
                if (is_num(b)) begin
                    pm_mag = d;
                    pm_mode = PM_LEN_DIGITS;
                end else if (b == bst_pkg::C_I) begin
                    pm_mode = PM_INT_START;
                end else if (b == bst_pkg::C_L) begin
                    have = 1;
                    if (pm_depth >= DEPTH_LIMIT) begin
                        t.kind = bst_pkg::K_ERR; t.code = bst_pkg::E_DEEP;
                        pm_mode = PM_ERROR;
                    end else begin
                        pm_depth++;
                        t.kind = bst_pkg::K_LSTART;
                    end
                end else if (b == bst_pkg::C_E && pm_depth > 0) begin
                    have = 1;
                    pm_depth--;
                    t.kind = bst_pkg::K_LEND;
                    if (pm_depth == 0) begin
                        t.done = 1'b1; pm_mode = PM_DONE;
                    end
                end else begin
                    have = 1; t.kind = bst_pkg::K_ERR; t.code = bst_pkg::E_TYPE;
                    pm_mode = PM_ERROR;
                end
            end
            PM_INT_START, PM_INT_MINUS, PM_INT_DIGITS: begin
                if (pm_mode == PM_INT_START && b == bst_pkg::C_MINUS) begin
                    pm_neg = 1'b1;
                    pm_mode = PM_INT_MINUS;
                end else if (pm_mode == PM_INT_DIGITS && b == bst_pkg::C_E) begin
                    have = 1;
                    t.kind = bst_pkg::K_INT;
                    t.int_value = pm_neg ? -pm_mag : pm_mag;
                    if (pm_depth == 0) begin
                        t.done = 1'b1; pm_mode = PM_DONE;
                    end else begin
                        pm_mode = PM_IDLE;
                    end
                end else if (is_num(b) && !(pm_mode == PM_INT_MINUS && b == bst_pkg::C_ZERO)
                             && !(pm_mode == PM_INT_DIGITS && pm_lz)) begin
                    lim = pm_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    if (pm_mag > (lim - d) / 10) begin
                        have = 1; t.kind = bst_pkg::K_ERR; t.code = bst_pkg::E_INT;
                        pm_mode = PM_ERROR;
                    end else begin
                        pm_mag = pm_mag * 10 + d;
                        pm_lz = (pm_mag == 0);
                        pm_mode = PM_INT_DIGITS;
                    end
                end else begin
                    have = 1; t.kind = bst_pkg::K_ERR; t.code = bst_pkg::E_INT;
                    pm_mode = PM_ERROR;
                end
            end
            PM_LEN_DIGITS: begin
                if (is_num(b)) begin
                    if (pm_mag > (64'hFFFF_FFFF - d) / 10) begin
                        have = 1; t.kind = bst_pkg::K_ERR; t.code = bst_pkg::E_LEN;
                        pm_mode = PM_ERROR;
                    end else begin
                        pm_mag = pm_mag * 10 + d;
                    end
                end else if (b == bst_pkg::C_COLON) begin
                    have = 1;
                    t.kind = bst_pkg::K_HDR;
                    t.len = pm_mag[31:0];
                    pm_left = pm_mag;
                    if (pm_mag != 0) pm_mode = PM_PAYLOAD;
                    else if (pm_depth == 0) begin
                        t.done = 1'b1; pm_mode = PM_DONE;
                    end else pm_mode = PM_IDLE;
                end else begin
                    have = 1; t.kind = bst_pkg::K_ERR; t.code = bst_pkg::E_LEN;
                    pm_mode = PM_ERROR;
                end
            end
            PM_PAYLOAD: begin
                have = 1;
                t.kind = bst_pkg::K_BYTE;
                t.payload = b;
                pm_left--;
                if (pm_left == 0) begin
                    if (pm_depth == 0) begin
                        t.done = 1'b1; pm_mode = PM_DONE;
                    end else pm_mode = PM_IDLE;
                end
            end
            default: ;
        endcase
        // Unfinished object at the final byte reports truncation
        if (eob && !(have && t.kind == bst_pkg::K_ERR) && pm_mode != PM_DONE
            && pm_mode != PM_ERROR) begin
            have = 1;
            t = '0;
            t.kind = bst_pkg::K_ERR;
            t.code = bst_pkg::E_TRUNC;
        end
        t.depth = pm_depth;
        if (have) token_queue.push_back(t);
        if (eob) parser_clear();
    endtask

    // Send one item and predict its token on acceptance
    task automatic send_byte(logic [7:0] b, logic eob);
        while (take_break()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!o_ready);
        predict_token(b, eob);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
    endtask

    // Receiver readiness
    always @(negedge i_clk) begin
        if (i_rst_n) i_ready <= !take_break();
    end

    // Compare each accepted token with the oldest prediction
    always @(posedge i_clk) begin
        bst_pkg::t_tok want;
        bst_pkg::t_tok got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_token_kind, o_int_value, o_string_length, o_payload_byte,
                    o_nesting_depth, o_error_code, o_object_done};
            if (token_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected token %p", got);
            end else begin
                want = token_queue.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("token mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic test_directed();
        send_text("i0e");
        send_text("i-1e");
        send_text("i9223372036854775807e");
        send_text("i-9223372036854775808e");
        send_text("i9223372036854775808e");
        send_text("ie");
        send_text("i-0e");
        send_text("i03e");
        send_text("i1xe");
        send_text("0:");
        send_text("0004:spam");
        send_text("4294967296:");
        send_text("3x");
        send_text("l4:abcdi5eli7eee");
        send_text("d3:abc");
        send_text("e");
        send_text("l5:ab");
        send_text("i5eTRAIL");
        send_text("lllllllllllllllllee");
        // an all-zero and an all-one byte as payload
        send_byte("2", 0); send_byte(":", 0); send_byte(8'h00, 0); send_byte(8'hFF, 1);
    endtask

    // Build a well-formed value of random shape
    function automatic string rand_value(int lvl);
        string s;
        int n;
        longint v;
        case ($urandom_range(lvl > 3 ? 1 : 2))
            0: begin
                v = $urandom_range(9) == 0 ? {$urandom, $urandom} : $urandom_range(2000);
                if ($urandom_range(1)) v = -v;
                if (v == 0) s = "i0e";
                else s = $sformatf("i%0de", v);
            end
            1: begin
                n = $urandom_range(6);
                s = $sformatf("%0d:", n);
                for (int k = 0; k < n; k++) s = {s, string'(8'($urandom))};
            end
            default: begin
                s = "l";
                n = $urandom_range(3);
                for (int k = 0; k < n; k++) s = {s, rand_value(lvl + 1)};
                s = {s, "e"};
            end
        endcase
        return s;
    endfunction

    task automatic test_random();
        string s;
        int cut;
        int sent;
        sent = 0;
        while (sent < 680) begin
            calm = (sent > 300 && sent < 420);
            s = rand_value(0);
            case ($urandom_range(9))
                0: s = s.substr(0, $urandom_range(s.len() - 1));
                1: begin
                    cut = $urandom_range(s.len() - 1);
                    s[cut] = 8'($urandom);
                end
                2: s = {s, "xe"};
                default: ;
            endcase
            send_text(s);
            sent += s.len();
        end
        calm = 0;
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count = 0;
        calm = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in_byte = '0;
        i_end_of_buffer = 1'b0;
        i_ready = 1'b0;
        parser_clear();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        i_valid <= 1'b0;
        // drain the pipeline
        while (token_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && token_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

[bencode_stream_tokenizer.f]
+incdir+hw/rtl
hw/rtl/bst_pkg.sv
hw/rtl/bst_front.sv
hw/rtl/bst_back.sv
hw/rtl/bencode_stream_tokenizer.sv
hw/rtl/bst_checker.sv
tb/tb_bencode_stream_tokenizer.sv
